### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the text terminal writer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### hw/rtl/ttw_pkg.sv
// Package for the text terminal writer: geometry, opcodes, control word types,
// microcode ROM and dispatch. No dependencies.
package ttw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int UPC_W   = 4;

  localparam logic [7:0] COLOR_RESET  = 8'h0F;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [ADDR_W-1:0] PTR_COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] PTR_LAST      = ADDR_W'(CELLS - 1);

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CHAR  = 2'd1,
    WR_BLANK = 2'd2
  } wr_sel_e;

  typedef enum logic {
    RD_CELL   = 1'b0,
    RD_SCROLL = 1'b1
  } rd_sel_e;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_ZERO = 2'd1,
    PTR_INC  = 2'd2
  } ptr_op_e;

  typedef enum logic [1:0] {
    CUR_HOLD    = 2'd0,
    CUR_HOME    = 2'd1,
    CUR_COL_INC = 2'd2,
    CUR_NEWLINE = 2'd3
  } cur_op_e;

  typedef enum logic [2:0] {
    COND_NONE          = 3'd0,
    COND_ALWAYS        = 3'd1,
    COND_START         = 3'd2,
    COND_COL_NOT_LAST  = 3'd3,
    COND_ROW_NOT_LAST  = 3'd4,
    COND_PTR_NOT_COPY  = 3'd5,
    COND_PTR_NOT_END   = 3'd6
  } cond_e;

  localparam logic [UPC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] S_PUT   = 4'd1;
  localparam logic [UPC_W-1:0] S_ADV   = 4'd2;
  localparam logic [UPC_W-1:0] S_COPY  = 4'd3;
  localparam logic [UPC_W-1:0] S_FLUSH = 4'd4;
  localparam logic [UPC_W-1:0] S_BLANK = 4'd5;
  localparam logic [UPC_W-1:0] S_DONE  = 4'd6;
  localparam logic [UPC_W-1:0] S_CLEAR = 4'd7;
  localparam logic [UPC_W-1:0] S_READ  = 4'd8;

  typedef struct packed {
    wr_sel_e          wr;
    rd_sel_e          rd;
    logic             copy;
    ptr_op_e          ptr_op;
    cur_op_e          cur_op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             done;
  } ucode_t;

  typedef struct packed {
    ucode_t uw;
    logic   accept;
  } ctrl_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
    logic ptr_copy_end;
    logic ptr_end;
  } stat_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    w = '0;
    case (upc)
      S_IDLE: begin
        w.cond   = COND_START;
        w.target = S_IDLE;
      end
      S_PUT: begin
        w.wr     = WR_CHAR;
        w.cur_op = CUR_COL_INC;
        w.cond   = COND_COL_NOT_LAST;
        w.target = S_DONE;
      end
      S_ADV: begin
        w.cur_op = CUR_NEWLINE;
        w.ptr_op = PTR_ZERO;
        w.cond   = COND_ROW_NOT_LAST;
        w.target = S_DONE;
      end
      S_COPY: begin
        w.rd     = RD_SCROLL;
        w.copy   = 1'b1;
        w.ptr_op = PTR_INC;
        w.cond   = COND_PTR_NOT_COPY;
        w.target = S_COPY;
      end
      S_FLUSH: begin
        w.cond   = COND_NONE;
      end
      S_BLANK: begin
        w.wr     = WR_BLANK;
        w.ptr_op = PTR_INC;
        w.cond   = COND_PTR_NOT_END;
        w.target = S_BLANK;
      end
      S_DONE: begin
        w.done   = 1'b1;
        w.cond   = COND_START;
        w.target = S_IDLE;
      end
      S_CLEAR: begin
        w.cur_op = CUR_HOME;
        w.ptr_op = PTR_ZERO;
        w.cond   = COND_ALWAYS;
        w.target = S_BLANK;
      end
      S_READ: begin
        w.rd     = RD_CELL;
        w.cond   = COND_ALWAYS;
        w.target = S_DONE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] op, input logic [7:0] ch);
    logic [UPC_W-1:0] s;
    case (op)
      OP_PUT:   s = (ch == NEWLINE_CHAR) ? S_ADV : S_PUT;
      OP_CLEAR: s = S_CLEAR;
      OP_READ:  s = S_READ;
      default:  s = S_DONE;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/ttw_useq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ttw_pkg.
module ttw_useq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic [1:0]     opcode_i,
  input  logic [7:0]     char_code_i,
  input  ttw_pkg::stat_t stat_i,
  output ttw_pkg::ctrl_t ctrl_o,
  output logic           busy
);
  import ttw_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d, upc_inc;
  ucode_t           cw;

  assign cw      = ucode_rom(upc_q);
  assign upc_inc = upc_q + 1'b1;

  assign ctrl_o.uw     = cw;
  assign ctrl_o.accept = (cw.cond == COND_START) && start;
  assign busy          = (cw.cond != COND_START);

  always_comb begin
    case (cw.cond)
      COND_NONE:         upc_d = upc_inc;
      COND_ALWAYS:       upc_d = cw.target;
      COND_START:        upc_d = start ? dispatch(opcode_i, char_code_i) : cw.target;
      COND_COL_NOT_LAST: upc_d = stat_i.col_last ? upc_inc : cw.target;
      COND_ROW_NOT_LAST: upc_d = stat_i.row_last ? upc_inc : cw.target;
      COND_PTR_NOT_COPY: upc_d = stat_i.ptr_copy_end ? upc_inc : cw.target;
      COND_PTR_NOT_END:  upc_d = stat_i.ptr_end ? upc_inc : cw.target;
      default:           upc_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

### hw/rtl/ttw_datapath.sv
// Datapath: cursor, sweep pointer, color register, latched transaction and
// the screen memory with registered read. Depends on ttw_pkg.
module ttw_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttw_pkg::ctrl_t      ctrl_i,
  output ttw_pkg::stat_t      stat_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          char_code_i,
  input  logic [ttw_pkg::ROW_W-1:0] cell_row_i,
  input  logic [ttw_pkg::COL_W-1:0] cell_col_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output logic [ttw_pkg::ROW_W-1:0] cursor_row_o,
  output logic [ttw_pkg::COL_W-1:0] cursor_col_o,
  output logic [7:0]          cell_char_o,
  output logic [7:0]          cell_color_o
);
  import ttw_pkg::*;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata_q;

  logic [7:0]        color_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] wptr_q;
  logic              copy_pend_q;

  logic [1:0]        op_q;
  logic [7:0]        ch_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;

  logic              rd_ok;
  logic [ADDR_W-1:0] cur_addr, cell_addr, raddr, waddr;
  logic [15:0]       wdata;
  logic              we;

  assign cur_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign cell_addr = ADDR_W'(rrow_q) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_q);
  assign rd_ok     = ({1'b0, rrow_q} < (ROW_W+1)'(ROWS)) &&
                     ({1'b0, rcol_q} < (COL_W+1)'(COLUMNS));

  assign stat_o.col_last     = (col_q == COL_W'(COLUMNS - 1));
  assign stat_o.row_last     = (row_q == ROW_W'(ROWS - 1));
  assign stat_o.ptr_copy_end = (ptr_q == PTR_COPY_LAST);
  assign stat_o.ptr_end      = (ptr_q == PTR_LAST);

  always_comb begin
    if (ctrl_i.uw.rd == RD_SCROLL) begin
      raddr = ptr_q + ADDR_W'(COLUMNS);
    end else begin
      raddr = rd_ok ? cell_addr : '0;
    end
  end

  // pending scroll copy takes the write port ahead of the microcode write
  always_comb begin
    we    = 1'b1;
    waddr = ptr_q;
    wdata = {color_q, BLANK_CHAR};
    if (copy_pend_q) begin
      waddr = wptr_q;
      wdata = rdata_q;
    end else begin
      case (ctrl_i.uw.wr)
        WR_CHAR: begin
          waddr = cur_addr;
          wdata = {color_q, ch_q};
        end
        WR_BLANK: begin
          waddr = ptr_q;
          wdata = {color_q, BLANK_CHAR};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    case (ctrl_i.uw.cur_op)
      CUR_HOME: begin
        row_d = '0;
        col_d = '0;
      end
      CUR_COL_INC: col_d = col_q + 1'b1;
      CUR_NEWLINE: begin
        col_d = '0;
        row_d = stat_o.row_last ? row_q : row_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctrl_i.uw.ptr_op)
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_q + 1'b1;
      default:  ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= COLOR_RESET;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      copy_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      row_q       <= row_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      copy_pend_q <= ctrl_i.uw.copy;
    end
  end

  always_ff @(posedge clk_i) begin
    wptr_q <= ptr_q;
    if (ctrl_i.accept) begin
      op_q   <= opcode_i;
      ch_q   <= char_code_i;
      rrow_q <= cell_row_i;
      rcol_q <= cell_col_i;
    end
  end

  assign cursor_row_o = row_q;
  assign cursor_col_o = col_q;
  assign cell_char_o  = (op_q == OP_READ && rd_ok) ? rdata_q[7:0] : 8'h00;
  assign cell_color_o = (op_q == OP_READ && rd_ok) ? rdata_q[15:8] : 8'h00;

endmodule

### hw/rtl/text_terminal_writer_unit.sv
// Top level of the text terminal writer: microcode sequencer plus datapath.
// Depends on ttw_pkg, ttw_useq, ttw_datapath and assert_macros.svh.
//
//   channel   handshake                  payload
//   command   start / busy               opcode_i, char_code_i, cell_row_i, cell_col_i
//   result    done_o (one-cycle strobe)  cursor_row_o, cursor_col_o, cell_char_o, cell_color_o
//   config    cfg_we_i                   cfg_wdata_i (text color)
//
// Put of a plain character: S_PUT, then S_DONE; read: S_READ, then S_DONE; unused opcode: S_DONE.
// Newline or wrap without scroll goes through S_ADV to S_DONE. Scroll runs S_COPY, S_FLUSH, S_BLANK
// (one cell copy per cycle through the single memory write port, then the blank row).
// Clear: S_CLEAR, then S_BLANK with one cell written per cycle.
// A new command is taken in the strobe cycle. Reset homes the cursor and sets the color
// to COLOR_RESET; screen memory is not reset and holds garbage until the first clear.
`include "assert_macros.svh"
module text_terminal_writer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] cell_row_i,
  input  logic [6:0] cell_col_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       done_o,
  output logic [4:0] cursor_row_o,
  output logic [6:0] cursor_col_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_color_o
);
  import ttw_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ttw_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .opcode_i    (opcode_i),
    .char_code_i (char_code_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .busy        (busy)
  );

  ttw_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .cell_char_o  (cell_char_o),
    .cell_color_o (cell_color_o)
  );

  assign done_o = ctrl.uw.done;

  `ASSERT_CLK(a_done_after_work, clk_i, rst_ni, done_o |-> ($past(busy) || ($past(opcode_i) == OP_NOP)), "strobe without work step")
  `ASSERT_NEVER(a_cursor_range, clk_i, rst_ni, done_o && (({1'b0, cursor_row_o} >= 6'(ROWS)) || ({1'b0, cursor_col_o} >= 8'(COLUMNS))), "cursor out of range")
  `ASSERT_CLK(a_read_latency, clk_i, rst_ni, (start && !busy && opcode_i == OP_READ) |=> ##1 done_o, "read transaction not done in two cycles")

endmodule
